// ===== hdl/ifp_pkg.sv =====
// Package: constants and types shared by the inverse fitness probability block.
`timescale 1ns / 1ps
package ifp_pkg;

	localparam int POP_MAX     = 64;
	localparam int ADDR_W      = $clog2(POP_MAX);
	localparam int CNT_W       = $clog2(POP_MAX + 1);
	localparam int FIT_W       = 32;
	localparam int EPS_W       = 16;
	localparam int PROB_W      = 17;
	localparam int PROB_FRAC   = 16;
	localparam int TOT_W       = 38;
	localparam int STEP_W      = 6;
	localparam int RECIP_STEPS = 32;
	localparam int NORM_STEPS  = PROB_W;

	localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_RECIP = 5'b00010,
		S_RD    = 5'b00100,
		S_LD    = 5'b01000,
		S_DIV   = 5'b10000
	} state_t;

endpackage

// ===== hdl/inverse_fitness_probabilities.sv =====
// Top level: inverse fitness selection probabilities with shared iterative divider.
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  input   | in_valid, in_stall, fitness, last_entry            | in
//  output  | out_valid, out_stall, entry_index, probability,    | out
//          | overflow, last_result                              |
//  config  | cfg_we, cfg_wdata (epsilon_raw)                    | in
//
// Load: an item is taken, then the divider forms its reciprocal (skipped when it
// saturates); no new item is taken until that work is done.
// Emit: per entry a RAM read, a divider load, the normalising division and an output
// load; the output load waits while out_stall holds the previous result.
// in_stall is high from acceptance until the item's work, and any emit run, is done.
// Reset clears the run state and sets epsilon_raw to 7; the store needs no clearing.
`timescale 1ns / 1ps
module inverse_fitness_probabilities (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ifp_pkg::EPS_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ifp_pkg::FIT_W-1:0]      fitness,
	input  logic                           last_entry,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ifp_pkg::ADDR_W-1:0]     entry_index,
	output logic [ifp_pkg::PROB_W-1:0]     probability,
	output logic                           overflow,
	output logic                           last_result
);

	import ifp_pkg::*;

	state_t               state_q;
	logic [EPS_W-1:0]     eps_q;
	logic [TOT_W-1:0]     total_q;
	logic [CNT_W-1:0]     count_q;
	logic                 dropped_q;
	logic                 last_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [STEP_W-1:0]    step_q;
	logic [TOT_W-1:0]     rem_q;
	logic [FIT_W-1:0]     quo_q;
	logic [TOT_W-1:0]     dvs_q;

	logic                 out_valid_q;
	logic [ADDR_W-1:0]    entry_index_q;
	logic [PROB_W-1:0]    probability_q;
	logic                 overflow_q;
	logic                 last_result_q;

	logic                 in_acc;
	logic                 room;
	logic [FIT_W:0]       denom;
	logic                 denom_sat;
	logic                 sat_load;
	logic                 recip_done;
	logic                 load_finish;
	logic                 finish;
	logic                 finish_last;
	logic [TOT_W:0]       rem_sh;
	logic [TOT_W+1:0]     diff;
	logic                 qbit;
	logic [TOT_W-1:0]     rem_next;
	logic [FIT_W-1:0]     quo_next;
	logic                 ram_we;
	logic [FIT_W-1:0]     ram_wdata;
	logic [FIT_W-1:0]     ram_rdata;
	logic                 out_free;
	logic                 put;
	logic                 put_last;
	logic [CNT_W-1:0]     idx_inc;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign room      = (count_q < CNT_W'(POP_MAX));
	assign denom     = {1'b0, fitness} + {{(FIT_W+1-EPS_W){1'b0}}, eps_q};
	assign denom_sat = (denom[FIT_W:1] == '0);
	assign sat_load  = in_acc && room && denom_sat;

	assign rem_sh   = {rem_q, quo_q[FIT_W-1]};
	assign diff     = {1'b0, rem_sh} - {2'b0, dvs_q};
	assign qbit     = !diff[TOT_W+1];
	assign rem_next = qbit ? diff[TOT_W-1:0] : rem_sh[TOT_W-1:0];
	assign quo_next = {quo_q[FIT_W-2:0], qbit};

	assign recip_done  = (state_q == S_RECIP) && (step_q == STEP_W'(1));
	assign load_finish = in_acc && !(room && !denom_sat);
	assign finish      = load_finish || recip_done;
	assign finish_last = recip_done ? last_q : last_entry;

	assign ram_we    = sat_load || recip_done;
	assign ram_wdata = recip_done ? quo_next : '1;

	ifp_ram #(
		.WIDTH (FIT_W),
		.DEPTH (POP_MAX)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign idx_inc  = {1'b0, idx_q} + CNT_W'(1);
	assign put      = (state_q == S_DIV) && (step_q == '0) && out_free;
	assign put_last = (idx_inc == count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			eps_q       <= EPS_RESET;
			total_q     <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				eps_q <= cfg_wdata;
			end
			if (ram_we) begin
				total_q <= total_q + {{(TOT_W-FIT_W){1'b0}}, ram_wdata};
				count_q <= count_q + CNT_W'(1);
			end
			if (out_valid_q && !out_stall && !put) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				idx_q   <= '0;
				state_q <= finish_last ? S_RD : S_IDLE;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						last_q <= last_entry;
						if (!room) begin
							dropped_q <= 1'b1;
						end else if (!denom_sat) begin
							step_q  <= STEP_W'(RECIP_STEPS);
							state_q <= S_RECIP;
						end
					end
				end
				S_RECIP: begin
					step_q <= step_q - STEP_W'(1);
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					step_q  <= STEP_W'(NORM_STEPS);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (step_q != '0) begin
						step_q <= step_q - STEP_W'(1);
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						if (put_last) begin
							total_q   <= '0;
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							idx_q   <= idx_inc[ADDR_W-1:0];
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// divider datapath and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			rem_q <= TOT_W'(1);
			quo_q <= '0;
			dvs_q <= {{(TOT_W-FIT_W-1){1'b0}}, denom};
		end else if (state_q == S_LD) begin
			rem_q <= {{(TOT_W-FIT_W+1){1'b0}}, ram_rdata[FIT_W-1:1]};
			quo_q <= {ram_rdata[0], {(FIT_W-1){1'b0}}};
			dvs_q <= total_q;
		end else if ((state_q == S_RECIP || state_q == S_DIV) && step_q != '0) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
		if (put) begin
			entry_index_q <= idx_q;
			probability_q <= (total_q == '0) ? '0 : quo_q[PROB_W-1:0];
			overflow_q    <= dropped_q;
			last_result_q <= put_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign entry_index = entry_index_q;
	assign probability = probability_q;
	assign overflow    = overflow_q;
	assign last_result = last_result_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(POP_MAX))
		else $error("entry count beyond capacity");

	a_prob_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> probability_q <= PROB_W'(1 << PROB_FRAC))
		else $error("probability above one");

	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		put && put_last |=> count_q == '0 && total_q == '0 && !dropped_q)
		else $error("run state not cleared after final result");

	a_no_write_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE || state_q == S_RECIP) && room)
		else $error("store written outside load or beyond capacity");

endmodule

// ===== hdl/ifp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ifp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
